// ----- design/diagonal_extent_finder_macros.svh -----
// assertion macros for the diagonal extent finder
// used by the controller and the datapath, expects clk and rst_n in scope
`ifndef DIAGONAL_EXTENT_FINDER_MACROS_SVH
`define DIAGONAL_EXTENT_FINDER_MACROS_SVH
`ifndef SYNTH
`define DEX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEX_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEX_ASSERT(label, prop, msg)
`define DEX_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- design/dex_pkg.sv -----
// shared types and constants for the diagonal extent finder
// no dependencies
package dex_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd1;

  localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;
  localparam logic [PIX_W-1:0] INK_LEVEL = 8'd0;

  localparam int ASTART_W = 10;
  localparam int AEND_W   = 9;
  localparam int MSTART_W = 10;
  localparam int MEND_W   = 10;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } dex_state_t;

  typedef struct packed {
    logic clear_en;
    logic pixel_en;
    logic scan_init;
    logic scan_step;
    logic scan_last;
    logic load_out;
  } dex_cmd_t;

  typedef struct packed {
    logic out_free;
  } dex_status_t;

endpackage

// ----- design/diagonal_extent_finder.sv -----
// ordinary pixels are taken one per cycle while idle
// after the frame-end pixel the scan walks h+w-1 diagonals, one per cycle, and the result is
// loaded into the output register once it is free; then all MAX_HEIGHT+MAX_WIDTH-1 addresses
// of both occupancy memories are swept clear, one diagonal per cycle
// reset: synchronous active-low, starts the clearing sweep, sizes return to 256
// config writes are taken in any cycle, the result waits in an output register
module diagonal_extent_finder #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dex_pkg::PIX_W-1:0]          in_tdata,   // pixel_value
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // anti_start, anti_end, main_start, main_end, zero pad
  output logic [dex_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [dex_pkg::OUT_USER_W-1:0]     out_tuser,  // anti_found, main_found
  input  logic                               cfg_we,
  input  logic [dex_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dex_pkg::CFG_W-1:0]          cfg_wdata
);
  import dex_pkg::*;

  localparam int DC = MAX_HEIGHT + MAX_WIDTH - 1;
  localparam int KW = $clog2(DC + 1);

  dex_cmd_t      cmd;
  dex_status_t   status;
  logic [KW-1:0] step_k;
  logic [KW-1:0] diag_n;

  dex_ctrl #(.MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tlast (in_tlast),
    .in_tready(in_tready),
    .diag_n   (diag_n),
    .status   (status),
    .cmd      (cmd),
    .step_k   (step_k)
  );

  dex_datapath #(.MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .step_k    (step_k),
    .status    (status),
    .diag_n    (diag_n),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ----- design/dex_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module dex_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 511
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- design/dex_ctrl.sv -----
// sequencer for pixel intake, diagonal scan, result hand-off and map clearing
// depends on dex_pkg and diagonal_extent_finder_macros.svh
`include "diagonal_extent_finder_macros.svh"
module dex_ctrl #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256,
  localparam int DC = MAX_HEIGHT + MAX_WIDTH - 1,
  localparam int KW = $clog2(DC + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  input  logic [KW-1:0]       diag_n,
  input  dex_pkg::dex_status_t status,
  output dex_pkg::dex_cmd_t    cmd,
  output logic [KW-1:0]       step_k
);
  import dex_pkg::*;

  dex_state_t state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (k_r >= KW'(DC - 1)) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.pixel_en = 1'b1;
          if (in_tlast) begin
            cmd.scan_init = 1'b1;
            k_nxt         = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (k_r >= diag_n) begin
          cmd.scan_last = 1'b1;
          state_nxt     = S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          k_nxt        = '0;
          state_nxt    = S_CLEAR;
        end
      end
      default: begin
        k_nxt     = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign step_k = k_r;

  `DEX_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == S_CLEAR && k_r == '0, "reset did not start clearing")
  `DEX_ASSERT(a_last_starts_scan, in_tvalid && in_tready && in_tlast |=> state_r == S_SCAN && k_r == '0, "frame end did not start scan")
  `DEX_ASSERT(a_load_then_clear, cmd.load_out |=> state_r == S_CLEAR && k_r == '0, "result request not followed by clearing")
  `DEX_ASSERT(a_drain_one, state_r == S_DRAIN |=> state_r == S_EMIT, "drain took more than one cycle")

endmodule

// ----- design/dex_datapath.sv -----
// position counters, occupancy maps, streaming cluster search and result register
// depends on dex_pkg, dex_ram and diagonal_extent_finder_macros.svh
`include "diagonal_extent_finder_macros.svh"
module dex_datapath #(
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WIDTH  = 256,
  localparam int DC = MAX_HEIGHT + MAX_WIDTH - 1,
  localparam int KW = $clog2(DC + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [dex_pkg::PIX_W-1:0]          in_tdata,
  input  logic                               cfg_we,
  input  logic [dex_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dex_pkg::CFG_W-1:0]          cfg_wdata,
  input  dex_pkg::dex_cmd_t                  cmd,
  input  logic [KW-1:0]                      step_k,
  output dex_pkg::dex_status_t               status,
  output logic [KW-1:0]                      diag_n,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dex_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [dex_pkg::OUT_USER_W-1:0]     out_tuser
);
  import dex_pkg::*;

  localparam int AW  = $clog2(DC);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SW  = KW + 2;

  // configuration
  logic [CFG_W-1:0] height_r, width_r;
  logic [HW-1:0] h_cl;
  logic [WW-1:0] w_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= DIM_RESET;
      width_r  <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (height_r == '0) begin
      h_cl = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(height_r);
    end
    if (width_r == '0) begin
      w_cl = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(width_r);
    end
  end

  assign diag_n = KW'(h_cl) + KW'(w_cl) - 1'b1;

  // raster position
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW:0] row_inc;
  logic [CW:0] col_inc;

  assign row_inc = {1'b0, row_r} + 1'b1;
  assign col_inc = {1'b0, col_r} + 1'b1;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.scan_init) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (cmd.pixel_en) begin
      if (col_inc >= (CW + 1)'(w_cl)) begin
        col_nxt = '0;
        row_nxt = (row_inc >= (RW + 1)'(h_cl)) ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // occupancy maps
  logic ink;
  logic map_we;
  logic map_wdata;
  logic [AW-1:0] anti_waddr, main_waddr, anti_raddr, main_raddr;
  logic anti_rdata, main_rdata;

  assign ink       = (in_tdata == INK_LEVEL);
  assign map_we    = cmd.clear_en | (cmd.pixel_en & ink);
  assign map_wdata = ~cmd.clear_en;

  always_comb begin
    if (cmd.clear_en) begin
      anti_waddr = step_k[AW-1:0];
      main_waddr = step_k[AW-1:0];
    end else begin
      anti_waddr = AW'(row_r) + AW'(col_r);
      main_waddr = AW'(col_r) + AW'(MAX_HEIGHT - 1) - AW'(row_r);
    end
  end

  // anti scans up from 0, main scans down from w-1
  logic [KW-1:0] main_base;
  assign main_base  = KW'(w_cl) + KW'(MAX_HEIGHT - 2);
  assign anti_raddr = step_k[AW-1:0];
  assign main_raddr = AW'(main_base - step_k);

  dex_ram #(.WIDTH(1), .DEPTH(DC)) u_anti_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(anti_waddr),
    .wdata(map_wdata),
    .raddr(anti_raddr),
    .rdata(anti_rdata)
  );

  dex_ram #(.WIDTH(1), .DEPTH(DC)) u_main_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(main_waddr),
    .wdata(map_wdata),
    .raddr(main_raddr),
    .rdata(main_rdata)
  );

  // step flags and index are registered to line up with the registered read data
  logic s1_valid_r, s1_last_r;
  logic [KW-1:0] s1_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= cmd.scan_step;
      s1_last_r  <= cmd.scan_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r <= step_k;
  end

  // cluster search
  logic a_found_r, a_done_r, a_pe_r, a_found_nxt, a_done_nxt, a_pe_nxt;
  logic m_found_r, m_done_r, m_pe_r, m_found_nxt, m_done_nxt, m_pe_nxt;
  logic signed [SW-1:0] a_start_r, a_end_r, m_start_r, m_end_r;
  logic signed [SW-1:0] a_start_nxt, a_end_nxt, m_start_nxt, m_end_nxt;
  logic signed [SW-1:0] ks, k_m1, w_m_k, neg_h;

  assign ks    = $signed({2'b00, s1_k_r});
  assign k_m1  = ks - SW'(1);
  assign w_m_k = $signed(SW'(w_cl)) - ks;
  assign neg_h = -$signed(SW'(h_cl));

  always_comb begin
    a_found_nxt = a_found_r;
    a_done_nxt  = a_done_r;
    a_pe_nxt    = a_pe_r;
    a_start_nxt = a_start_r;
    a_end_nxt   = a_end_r;
    m_found_nxt = m_found_r;
    m_done_nxt  = m_done_r;
    m_pe_nxt    = m_pe_r;
    m_start_nxt = m_start_r;
    m_end_nxt   = m_end_r;
    if (cmd.scan_init) begin
      a_found_nxt = 1'b0;
      a_done_nxt  = 1'b0;
      a_pe_nxt    = 1'b0;
      m_found_nxt = 1'b0;
      m_done_nxt  = 1'b0;
      m_pe_nxt    = 1'b0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        if (a_found_r && !a_done_r) begin
          a_done_nxt = 1'b1;
          a_end_nxt  = a_pe_r ? k_m1 : ks;
        end
        if (m_found_r && !m_done_r) begin
          m_done_nxt = 1'b1;
          m_end_nxt  = neg_h;
        end
      end else begin
        if (!a_found_r) begin
          if (anti_rdata) begin
            a_found_nxt = 1'b1;
            a_start_nxt = k_m1;
            a_pe_nxt    = 1'b0;
          end
        end else if (!a_done_r) begin
          if (!anti_rdata) begin
            if (a_pe_r) begin
              a_done_nxt = 1'b1;
              a_end_nxt  = k_m1;
            end else begin
              a_pe_nxt = 1'b1;
            end
          end else begin
            a_pe_nxt = 1'b0;
          end
        end
        if (!m_found_r) begin
          if (main_rdata) begin
            m_found_nxt = 1'b1;
            m_start_nxt = w_m_k;
            m_pe_nxt    = 1'b0;
          end
        end else if (!m_done_r) begin
          if (!main_rdata) begin
            if (m_pe_r) begin
              m_done_nxt = 1'b1;
              m_end_nxt  = w_m_k;
            end else begin
              m_pe_nxt = 1'b1;
            end
          end else begin
            m_pe_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_found_r <= 1'b0;
      a_done_r  <= 1'b0;
      a_pe_r    <= 1'b0;
      m_found_r <= 1'b0;
      m_done_r  <= 1'b0;
      m_pe_r    <= 1'b0;
    end else begin
      a_found_r <= a_found_nxt;
      a_done_r  <= a_done_nxt;
      a_pe_r    <= a_pe_nxt;
      m_found_r <= m_found_nxt;
      m_done_r  <= m_done_nxt;
      m_pe_r    <= m_pe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_start_r <= a_start_nxt;
    a_end_r   <= a_end_nxt;
    m_start_r <= m_start_nxt;
    m_end_r   <= m_end_nxt;
  end

  // result register
  logic out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic [ASTART_W-1:0] f_astart;
  logic [AEND_W-1:0]   f_aend;
  logic [MSTART_W-1:0] f_mstart;
  logic [MEND_W-1:0]   f_mend;

  assign status.out_free = ~out_valid_r | out_tready;

  assign f_astart = a_found_r ? ASTART_W'(a_start_r) : '0;
  assign f_aend   = a_found_r ? AEND_W'(a_end_r) : '0;
  assign f_mstart = m_found_r ? MSTART_W'(m_start_r) : '0;
  assign f_mend   = m_found_r ? MEND_W'(m_end_r) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, f_mend, f_mstart, f_aend, f_astart};
      out_user_nxt  = {m_found_r, a_found_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `DEX_ASSERT(a_load_when_free, cmd.load_out |-> !out_valid_r || out_tready, "result overwritten before taken")
  `DEX_ASSERT(a_done_needs_found, a_done_r || m_done_r |-> (a_found_r || !a_done_r) && (m_found_r || !m_done_r), "cluster closed without a hit")
  `DEX_ASSERT(a_init_clears, cmd.scan_init |=> !a_found_r && !m_found_r && !a_done_r && !m_done_r, "scan flags not cleared at frame end")

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for diagonal_extent_finder: streams small binary frames through the block and
// checks every extent result against a local predictor of the diagonal scan
// depends on dex_pkg and the diagonal_extent_finder rtl
module testbench;
  import dex_pkg::*;

  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_WIDTH    = 256;
  localparam int DIAG_COUNT   = MAX_HEIGHT + MAX_WIDTH - 1;
  localparam int AEND_LSB     = ASTART_W;
  localparam int MSTART_LSB   = AEND_LSB + AEND_W;
  localparam int MEND_LSB     = MSTART_LSB + MSTART_W;
  localparam int IDLE_WAIT    = 2 * (MAX_HEIGHT + MAX_WIDTH);
  localparam int RANDOM_ITEMS = 550;
  localparam int LIMIT_CYCLES = 4000000;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } px_req_t;

  typedef struct packed {
    logic                anti_found;
    logic [ASTART_W-1:0] anti_start;
    logic [AEND_W-1:0]   anti_end;
    logic                main_found;
    logic [MSTART_W-1:0] main_start;
    logic [MEND_W-1:0]   main_end;
  } extent_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;   // pixel_value
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  // anti_start, anti_end, main_start, main_end, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;       // anti_found, main_found
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_HEIGHT;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  px_req_t pending_px[$];
  extent_t extents_due[$];
  bit      anti_map[DIAG_COUNT];
  bit      main_map[DIAG_COUNT];
  int      row_pos = 0;
  int      col_pos = 0;
  logic [CFG_W-1:0] cfg_height = DIM_RESET;
  logic [CFG_W-1:0] cfg_width  = DIM_RESET;
  int      errors = 0;
  bit      in_taken = 1'b0;
  int      gap_left = 0;
  int      burst_left = 0;
  int      stall_left = 0;
  int      ready_mode = 0;

  diagonal_extent_finder #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic last);
    int h, w, n, lo, hi, c, e, first, astart, aend, mstart, mend;
    extent_t res;
    h = eff_dim(cfg_height, MAX_HEIGHT);
    w = eff_dim(cfg_width, MAX_WIDTH);
    if (pix == INK_LEVEL) begin
      anti_map[row_pos + col_pos] = 1'b1;
      main_map[col_pos + MAX_HEIGHT - 1 - row_pos] = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    if (last) begin
      res = '0;
      // anti-diagonals scanned upward
      n = h + w - 1;
      first = -1;
      for (c = 0; c < n && first < 0; c++)
        if (anti_map[c]) first = c;
      if (first >= 0) begin
        aend = n;
        for (e = first + 1; e < n && aend == n; e++)
          if (!anti_map[e] && (e + 1 >= n || !anti_map[e + 1])) aend = e;
        astart = first - 1;
        res.anti_found = 1'b1;
        res.anti_start = astart[ASTART_W-1:0];
        res.anti_end   = aend[AEND_W-1:0];
      end
      // main diagonals scanned downward
      lo = 1 - h;
      hi = w - 1;
      first = lo - 1;
      for (c = hi; c >= lo && first < lo; c--)
        if (main_map[c + MAX_HEIGHT - 1]) first = c;
      if (first >= lo) begin
        mend = -h;
        for (e = first - 1; e >= lo && mend == -h; e--)
          if (!main_map[e + MAX_HEIGHT - 1] && e - 1 >= lo && !main_map[e + MAX_HEIGHT - 2])
            mend = e;
        mstart = first + 1;
        res.main_found = 1'b1;
        res.main_start = mstart[MSTART_W-1:0];
        res.main_end   = mend[MEND_W-1:0];
      end
      extents_due.push_back(res);
      for (c = 0; c < DIAG_COUNT; c++) begin
        anti_map[c] = 1'b0;
        main_map[c] = 1'b0;
      end
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_extents();
    extent_t want;
    if (extents_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
               $time, out_tuser, out_tdata);
    end else begin
      want = extents_due.pop_front();
      check_field("anti_found", 10'(want.anti_found), 10'(out_tuser[0]));
      check_field("anti_start", 10'(want.anti_start), 10'(out_tdata[0 +: ASTART_W]));
      check_field("anti_end", 10'(want.anti_end), 10'(out_tdata[AEND_LSB +: AEND_W]));
      check_field("main_found", 10'(want.main_found), 10'(out_tuser[1]));
      check_field("main_start", 10'(want.main_start), 10'(out_tdata[MSTART_LSB +: MSTART_W]));
      check_field("main_end", 10'(want.main_end), 10'(out_tdata[MEND_LSB +: MEND_W]));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_tvalid && (in_tready === 1'b1);
      if (in_taken) take_pixel(in_tdata, in_tlast);
      if (out_tvalid === 1'b1 && out_tready) compare_extents();
    end
  end

  always @(negedge clk) begin : feed
    px_req_t req;
    if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_px.size() > 0) begin
        req = pending_px.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.value;
        in_tlast  <= req.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (ready_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_tready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  task automatic push_px(input logic [PIX_W-1:0] value, input logic last);
    px_req_t req;
    req.value = value;
    req.last  = last;
    pending_px.push_back(req);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_HEIGHT) cfg_height = value;
    else cfg_width = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (!(pending_px.size() == 0 && !in_tvalid && extents_due.size() == 0))
      @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CFG_W'($urandom_range(0, 511));
    if (sel == 1) begin
      case ($urandom_range(0, 3))
        0: return 9'd0;
        1: return 9'd1;
        2: return 9'd256;
        default: return 9'd511;
      endcase
    end
    return CFG_W'($urandom_range(1, 10));
  endfunction

  task automatic push_frame(input int len, input int shape, input bit close);
    int h, w, r, c, k, a, span, pct;
    bit ink;
    logic [PIX_W-1:0] v;
    h = eff_dim(cfg_height, MAX_HEIGHT);
    w = eff_dim(cfg_width, MAX_WIDTH);
    a = $urandom_range(0, h + w - 2);
    span = $urandom_range(0, 3);
    case (shape)
      1: pct = 10;
      2: pct = 30;
      3: pct = 60;
      4: pct = 95;
      default: pct = 0;
    endcase
    r = 0;
    c = 0;
    for (k = 0; k < len; k++) begin
      // bands concentrate ink on a few neighbouring diagonals, with holes
      if (shape == 5)
        ink = (r + c >= a) && (r + c <= a + span) && ($urandom_range(0, 3) != 0);
      else if (shape == 6)
        ink = (c - r + h - 1 >= a) && (c - r + h - 1 <= a + span) && ($urandom_range(0, 3) != 0);
      else
        ink = ($urandom_range(0, 99) < pct);
      v = ink ? INK_LEVEL : PIX_W'($urandom_range(1, 255));
      push_px(v, close && (k == len - 1));
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
  endtask

  initial begin
    int sent, pick, frames, f, area, kind, len, h, w;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size, ink at the first and third pixels of the first row, then a frame without ink
    push_px(INK_LEVEL, 1'b0);
    push_px(8'hFF, 1'b0);
    push_px(INK_LEVEL, 1'b1);
    push_px(8'hAA, 1'b0);
    push_px(8'h55, 1'b0);
    push_px(8'hFF, 1'b1);
    wait_idle();
    // zero sizes act as one, extra pixels wrap onto the single cell
    write_reg(REG_HEIGHT, 9'd0);
    write_reg(REG_WIDTH, 9'd0);
    push_px(INK_LEVEL, 1'b1);
    push_px(8'hFF, 1'b0);
    push_px(INK_LEVEL, 1'b1);
    wait_idle();
    // oversized values clamp to the maximum
    write_reg(REG_HEIGHT, 9'd511);
    write_reg(REG_WIDTH, 9'd511);
    repeat (4) push_px(INK_LEVEL, 1'b0);
    push_px(8'h80, 1'b1);
    wait_idle();
    // ink on the lowest main and highest anti diagonal
    write_reg(REG_HEIGHT, 9'd2);
    write_reg(REG_WIDTH, 9'd4);
    push_px(8'hFF, 1'b0);
    push_px(INK_LEVEL, 1'b0);
    push_px(8'hFF, 1'b0);
    push_px(8'h7F, 1'b0);
    push_px(INK_LEVEL, 1'b0);
    push_px(8'hFE, 1'b0);
    push_px(8'h01, 1'b0);
    push_px(INK_LEVEL, 1'b1);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 3);
      if (pick != 0) write_reg(REG_HEIGHT, pick_dim());
      if (pick != 1) write_reg(REG_WIDTH, pick_dim());
      h = eff_dim(cfg_height, MAX_HEIGHT);
      w = eff_dim(cfg_width, MAX_WIDTH);
      area = h * w;
      frames = $urandom_range(1, 4);
      for (f = 0; f < frames; f++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6)
          len = (area <= 64) ? area : $urandom_range(1, 48);
        else if (kind < 8)
          len = $urandom_range(1, (area < 20) ? area : 20);
        else
          len = (area <= 48) ? area + $urandom_range(1, 12) : $urandom_range(1, 48);
        push_frame(len, $urandom_range(0, 6), 1'b1);
        sent += len;
      end
      // leave a frame open so the next size applies mid-frame
      if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 6);
        push_frame(len, $urandom_range(0, 6), 1'b0);
        sent += len;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
